// ===== src/point_deque_distance_ranker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point deque distance ranker
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POINT_DEQUE_DISTANCE_RANKER_UNIT_MACROS_SVH
`define POINT_DEQUE_DISTANCE_RANKER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PDR_ASSERT_NEXT_NORST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Types, constants and helper functions for the point deque distance ranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdr_pkg;

    localparam int CAPACITY   = 16;
    localparam int COORD_BITS = 16;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DIST_W = 2 * COORD_BITS;
    localparam int EXT_W  = (COORD_BITS > 16) ? COORD_BITS : 16;

    // Request codes
    localparam logic [3:0] REQ_PUSH_BACK   = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT  = 4'd1;
    localparam logic [3:0] REQ_POP_BACK    = 4'd2;
    localparam logic [3:0] REQ_POP_FRONT   = 4'd3;
    localparam logic [3:0] REQ_CLEAR       = 4'd4;
    localparam logic [3:0] REQ_FIND_MAX    = 4'd5;
    localparam logic [3:0] REQ_FIND_MIN    = 4'd6;
    localparam logic [3:0] REQ_TOGGLE_DESC = 4'd7;
    localparam logic [3:0] REQ_TOGGLE_ASC  = 4'd8;
    localparam logic [3:0] REQ_LIST        = 4'd9;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // View modes
    localparam logic [1:0] VIEW_STORED = 2'd0;
    localparam logic [1:0] VIEW_DESC   = 2'd1;
    localparam logic [1:0] VIEW_ASC    = 2'd2;

    typedef logic [DIST_W-1:0] t_dist;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        t_dist  dsq;
        t_point pt;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_wr;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        label;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } t_res;

    // Keeps the low COORD_BITS of a 16-bit field, sign-extending when wider.
    function automatic logic signed [COORD_BITS-1:0] narrow(input logic signed [15:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[COORD_BITS-1:0];
    endfunction

    // Brings a stored coordinate back to the 16-bit result field.
    function automatic logic signed [15:0] to_out(input logic signed [COORD_BITS-1:0] c);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[15:0];
    endfunction

    // Physical slot of a deque position.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0]  p);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
        if (s >= (CNT_W+1)'(CAPACITY)) begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ===== src/pdr_store.sv =====
// ----------------------------------------------------------------------------
// pdr_store
// Point memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_store (
    input  logic                      i_clk,
    input  pdr_pkg::t_wr              i_wr,
    input  logic [pdr_pkg::SLOT_W-1:0] i_rd_addr,
    output pdr_pkg::t_entry           o_rd_data
);
    import pdr_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== src/pdr_sqdist.sv =====
// ----------------------------------------------------------------------------
// pdr_sqdist
// Squared distance of a point, one coordinate per cycle on one multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_sqdist (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pdr_pkg::t_point i_pt,
    output logic            o_done,
    output pdr_pkg::t_dist  o_dist
);
    import pdr_pkg::*;

    logic        r_busy;
    logic [1:0]  r_k;
    logic        r_done;
    t_point      r_pt;
    t_dist       r_prod;
    t_dist       r_acc;

    logic signed [COORD_BITS-1:0] coord;
    logic signed [DIST_W-1:0]     sq;

    always_comb begin
        case (r_k)
            2'd0:    coord = r_pt.x;
            2'd1:    coord = r_pt.y;
            default: coord = r_pt.z;
        endcase
    end

    assign sq = coord * coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_k == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
                r_pt   <= i_pt;
                r_acc  <= '0;
            end else if (r_busy) begin
                // The product of the previous cycle is summed while the next
                // coordinate is squared.
                if (r_k != 2'd3) begin
                    r_prod <= $unsigned(sq);
                end else begin
                    r_busy <= 1'b0;
                end
                if (r_k != 2'd0) begin
                    r_acc <= r_acc + r_prod;
                end
                r_k <= r_k + 2'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_dist = r_acc;

endmodule

// ===== src/pdr_out_stage.sv =====
// ----------------------------------------------------------------------------
// pdr_out_stage
// Output register of the result stream; holds a word until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  pdr_pkg::t_res i_res,
    input  logic          i_tready,
    output logic          o_free,
    output logic          o_tvalid,
    output logic [63:0]   o_tdata,
    output logic [1:0]    o_tuser,
    output logic          o_tlast
);
    import pdr_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_res.z, r_res.y, r_res.x, r_res.label};
    assign o_tuser  = r_res.status;
    assign o_tlast  = r_res.last;

endmodule

// ===== src/point_deque_distance_ranker_unit.sv =====
// ----------------------------------------------------------------------------
// point_deque_distance_ranker_unit
// Bounded deque of 3D points with farthest/nearest search and sorted listing.
// ----------------------------------------------------------------------------
// Requests arrive on the s-side stream: tuser carries the request code and
// tdata the point (x, y, z). Results leave on the m-side stream, one word per
// listed entry, with tlast on the final word of a request. Only one request is
// worked on at a time; s_tready is high while the sequencer is idle, also when
// a finished word still sits in the output register.
// Steps per request, with n entries held after the request:
//   push: accept, squared distance on the multiplier, memory write, then listing.
//   pop, toggle and list: accept, then listing.
//   stored listing: one memory read and one output per entry.
//   sorted listing: n ranks, one output each; each rank is a full scan of the memory
//   through its single read port.
//   find: one scan of the memory; clear and error answers: a single word.
// A stalled receiver freezes the sequencer at the next output word; nothing is
// dropped. Reset empties the deque, returns the view to stored order and
// leaves the point memory undefined; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_deque_distance_ranker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // point_x, point_y, point_z
    input  logic [3:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // label, out_x, out_y, out_z
    output logic [1:0]  o_m_tuser,   // status
    output logic        o_m_tlast
);
    import pdr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_WR    = 4'd2;
    localparam logic [3:0] S_LST   = 4'd3;
    localparam logic [3:0] S_LRD   = 4'd4;
    localparam logic [3:0] S_LWR   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_SEMIT = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [15:0]       r_first;
    logic [1:0]        r_view;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_dpos;
    logic              r_dv;
    logic              r_have;
    t_dist             r_bd;
    t_point            r_bpt;
    logic [CNT_W-1:0]  r_bpos;
    logic [CAPACITY-1:0] r_used;
    logic [CNT_W-1:0]  r_rank;
    logic              r_find;
    logic              r_want_max;
    t_res              r_pend;
    logic [SLOT_W-1:0] r_wslot;
    t_point            r_pt;

    logic              sq_start;
    logic              sq_done;
    t_dist             sq_dist;
    t_wr               wr;
    t_entry            rd;
    logic              out_load;
    logic              out_free;
    t_res              out_res;
    t_res              stored_res;
    t_res              sorted_res;
    t_point            in_pt;
    logic [3:0]        req;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  last_pos;
    logic              better;
    logic              scan_done;
    logic [SLOT_W-1:0] head_dec;
    logic [SLOT_W-1:0] head_inc;
    logic [1:0]        idle_status;

    assign req      = i_s_tuser;
    assign in_pt.x  = narrow(i_s_tdata[15:0]);
    assign in_pt.y  = narrow(i_s_tdata[31:16]);
    assign in_pt.z  = narrow(i_s_tdata[47:32]);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign last_pos = r_count - CNT_W'(1);
    assign head_dec = (r_head == '0) ? SLOT_W'(CAPACITY - 1) : r_head - SLOT_W'(1);
    assign head_inc = (r_head == SLOT_W'(CAPACITY - 1)) ? '0 : r_head + SLOT_W'(1);

    // Status of a word that answers a request directly from the idle state.
    assign idle_status = (full && (req inside {REQ_PUSH_BACK, REQ_PUSH_FRONT})) ? ST_FULL :
                         (empty && (req inside {REQ_POP_BACK, REQ_POP_FRONT,
                                                REQ_FIND_MAX, REQ_FIND_MIN})) ? ST_EMPTY :
                         ST_OK;

    assign o_s_tready = (r_state == S_IDLE);

    // Scan compare: strict comparison keeps the earliest entry on ties.
    assign better = r_dv && !r_used[r_dpos[SLOT_W-1:0]] &&
                    (!r_have || (r_want_max ? (rd.dsq > r_bd) : (rd.dsq < r_bd)));
    assign scan_done = (r_pos >= r_count) && !r_dv;

    always_comb begin
        stored_res.status = ST_OK;
        stored_res.label  = r_first + 16'(r_pos);
        stored_res.x      = to_out(rd.pt.x);
        stored_res.y      = to_out(rd.pt.y);
        stored_res.z      = to_out(rd.pt.z);
        stored_res.last   = (r_pos == last_pos);

        sorted_res.status = ST_OK;
        sorted_res.label  = r_find ? (r_first + 16'(r_bpos)) : 16'(r_rank);
        sorted_res.x      = to_out(r_bpt.x);
        sorted_res.y      = to_out(r_bpt.y);
        sorted_res.z      = to_out(r_bpt.z);
        sorted_res.last   = r_find || (r_rank == last_pos);
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        out_res  = r_pend;
        sq_start = 1'b0;
        wr.en    = 1'b0;
        wr.addr  = r_wslot;
        wr.data  = '{dsq: sq_dist, pt: r_pt};
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (req) inside
                        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                            if (full) begin
                                n_state = S_EMIT;
                            end else begin
                                sq_start = 1'b1;
                                n_state  = S_SQ;
                            end
                        end
                        REQ_POP_BACK, REQ_POP_FRONT: begin
                            n_state = empty ? S_EMIT : S_LST;
                        end
                        REQ_CLEAR: n_state = S_EMIT;
                        REQ_FIND_MAX, REQ_FIND_MIN: begin
                            n_state = empty ? S_EMIT : S_SCAN;
                        end
                        REQ_TOGGLE_DESC, REQ_TOGGLE_ASC, REQ_LIST: n_state = S_LST;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                wr.en   = 1'b1;
                n_state = S_LST;
            end
            S_LST: begin
                if (empty) begin
                    n_state = S_EMIT;
                end else if (r_view == VIEW_DESC || r_view == VIEW_ASC) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_LRD: n_state = S_LWR;
            S_LWR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = stored_res;
                    n_state  = stored_res.last ? S_IDLE : S_LRD;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_SEMIT;
                end
            end
            S_SEMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = sorted_res;
                    n_state  = sorted_res.last ? S_IDLE : S_SCAN;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_first <= '0;
            r_view  <= VIEW_STORED;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_pend <= '{status: idle_status, label: '0, x: '0, y: '0, z: '0,
                                    last: 1'b1};
                        case (req) inside
                            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                                if (!full) begin
                                    r_pt    <= in_pt;
                                    r_count <= r_count + CNT_W'(1);
                                    if (req == REQ_PUSH_BACK) begin
                                        r_wslot <= slot_of(r_head, r_count);
                                    end else begin
                                        r_wslot <= head_dec;
                                        r_head  <= head_dec;
                                        // At label zero the entries are renumbered
                                        // instead, so the first label stays put.
                                        if (r_first != '0) begin
                                            r_first <= r_first - 16'd1;
                                        end
                                    end
                                end
                            end
                            REQ_POP_BACK, REQ_POP_FRONT: begin
                                if (!empty) begin
                                    r_count <= r_count - CNT_W'(1);
                                    if (r_count == CNT_W'(1)) begin
                                        r_head  <= '0;
                                        r_first <= '0;
                                    end else if (req == REQ_POP_FRONT) begin
                                        r_head  <= head_inc;
                                        r_first <= r_first + 16'd1;
                                    end
                                end
                            end
                            REQ_CLEAR: begin
                                r_count <= '0;
                                r_head  <= '0;
                                r_first <= '0;
                            end
                            REQ_FIND_MAX, REQ_FIND_MIN: begin
                                r_find     <= 1'b1;
                                r_want_max <= (req == REQ_FIND_MAX);
                                r_used     <= '0;
                                r_pos      <= '0;
                                r_dv       <= 1'b0;
                                r_have     <= 1'b0;
                            end
                            REQ_TOGGLE_DESC: begin
                                r_view <= (r_view == VIEW_DESC) ? VIEW_STORED : VIEW_DESC;
                            end
                            REQ_TOGGLE_ASC: begin
                                r_view <= (r_view == VIEW_ASC) ? VIEW_STORED : VIEW_ASC;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LST: begin
                    r_pend     <= '{status: ST_EMPTY, label: '0, x: '0, y: '0, z: '0,
                                    last: 1'b1};
                    r_find     <= 1'b0;
                    r_want_max <= (r_view == VIEW_DESC);
                    r_used     <= '0;
                    r_rank     <= '0;
                    r_pos      <= '0;
                    r_dv       <= 1'b0;
                    r_have     <= 1'b0;
                end
                S_LWR: begin
                    if (out_free) begin
                        r_pos <= r_pos + CNT_W'(1);
                    end
                end
                S_SCAN: begin
                    // A read is issued for r_pos while the word read for the
                    // previous position is compared.
                    r_dv   <= (r_pos < r_count);
                    r_dpos <= r_pos;
                    if (r_pos < r_count) begin
                        r_pos <= r_pos + CNT_W'(1);
                    end
                    if (better) begin
                        r_have <= 1'b1;
                        r_bd   <= rd.dsq;
                        r_bpt  <= rd.pt;
                        r_bpos <= r_dpos;
                    end
                end
                S_SEMIT: begin
                    if (out_free) begin
                        r_used[r_bpos[SLOT_W-1:0]] <= 1'b1;
                        r_rank <= r_rank + CNT_W'(1);
                        r_pos  <= '0;
                        r_dv   <= 1'b0;
                        r_have <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    pdr_sqdist u_sqdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_pt    (in_pt),
        .o_done  (sq_done),
        .o_dist  (sq_dist)
    );

    // The write happens in its own state, so no read of the same entry is in
    // flight; no forwarding path is needed.
    pdr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (slot_of(r_head, r_pos)),
        .o_rd_data (rd)
    );

    pdr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_res    (out_res),
        .i_tready (i_m_tready),
        .o_free   (out_free),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule

// ===== src/pdr_checker.sv =====
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks of the point deque distance ranker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_deque_distance_ranker_unit_macros.svh"

module pdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import pdr_pkg::*;

    // The sequencer comes out of reset ready for a request.
    `PDR_ASSERT_NEXT_NORST(a_ready_after_reset, i_clk, !i_rst_n, o_s_tready, "not ready after reset")

    // Only the three defined status codes are ever shown.
    `PDR_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_m_tvalid, o_m_tuser == ST_OK || o_m_tuser == ST_FULL || o_m_tuser == ST_EMPTY, "undefined status code")

    // An error answer is the single, final word of its request.
    `PDR_ASSERT_IMP(a_error_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK, o_m_tlast, "error word without tlast")

    // An error answer carries no label and no point.
    `PDR_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK, o_m_tdata == '0, "error word with data")

    // A stalled result word holds.
    `PDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled word changed")

endmodule

bind point_deque_distance_ranker_unit pdr_checker u_pdr_checker (.*);
